// ===== sv/spuv_pkg.sv =====
// shared types and constants for the safe path utf-8 validator
package spuv_pkg;

    // one input beat as held in the input register
    typedef struct packed {
        logic       has_byte;
        logic [7:0] path_byte;
        logic       is_last;
    } item_t;

    // verdict handed from the checker to the result register
    typedef struct packed {
        logic load;
        logic ok;
    } result_t;

    // running state of the path being checked
    typedef struct packed {
        logic        failed;
        logic [1:0]  bytes_pending;
        logic [2:0]  sequence_length;
        logic [20:0] partial_codepoint;
        logic [1:0]  component_length;
        logic        component_only_dots;
    } path_state_t;

    localparam path_state_t STATE_CLEAR = '{
        failed:              1'b0,
        bytes_pending:       2'd0,
        sequence_length:     3'd0,
        partial_codepoint:   21'd0,
        component_length:    2'd0,
        component_only_dots: 1'b1
    };

    // utf-8 sequence lengths
    localparam logic [2:0] SEQ_NONE = 3'd0;
    localparam logic [2:0] SEQ_LEN2 = 3'd2;
    localparam logic [2:0] SEQ_LEN3 = 3'd3;
    localparam logic [2:0] SEQ_LEN4 = 3'd4;

    // code point limits
    localparam logic [20:0] CP_MIN2      = 21'h000080;
    localparam logic [20:0] CP_MIN3      = 21'h000800;
    localparam logic [20:0] CP_MIN4      = 21'h010000;
    localparam logic [20:0] CP_MAX       = 21'h10ffff;
    localparam logic [20:0] CP_SURR_LO   = 21'h00d800;
    localparam logic [20:0] CP_SURR_HI   = 21'h00dfff;

    // special path bytes
    localparam logic [7:0] BYTE_SLASH     = 8'h2f;
    localparam logic [7:0] BYTE_DOT       = 8'h2e;
    localparam logic [7:0] BYTE_BACKSLASH = 8'h5c;
    localparam logic [7:0] BYTE_COLON     = 8'h3a;

    // component length saturates here
    localparam logic [1:0] COMP_LEN_MAX = 2'd3;

endpackage

// ===== sv/spuv_in_stage.sv =====
// input register for path beats
module spuv_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                has_byte,
    input  logic [7:0]          path_byte,
    input  logic                is_last,
    input  logic                take,
    output spuv_pkg::item_t     item,
    output logic                item_valid
);
    import spuv_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // room whenever the held beat leaves this cycle
    assign in_ready   = !valid_reg || take;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= '{has_byte: has_byte, path_byte: path_byte, is_last: is_last};
        end
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;

endmodule

// ===== sv/spuv_checker.sv =====
// utf-8 decode and path component rules, one byte per step
module spuv_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  spuv_pkg::item_t     item,
    output spuv_pkg::result_t   res
);
    import spuv_pkg::*;

    path_state_t state_reg;
    path_state_t state_next;
    path_state_t upd;
    logic [7:0]  b;
    logic [20:0] cp_shift;
    logic        cp_bad;

    // empty, "." or ".." component
    function automatic logic bad_component(input path_state_t s);
        bad_component = (s.component_length == 2'd0) ||
                        (s.component_only_dots && (s.component_length != COMP_LEN_MAX));
    endfunction

    assign b        = item.path_byte;
    assign cp_shift = {state_reg.partial_codepoint[14:0], b[5:0]};

    // overlong, surrogate or out of range on the completed code point
    assign cp_bad = ((state_reg.sequence_length == SEQ_LEN2) && (cp_shift < CP_MIN2)) ||
                    ((state_reg.sequence_length == SEQ_LEN3) && (cp_shift < CP_MIN3)) ||
                    ((state_reg.sequence_length == SEQ_LEN4) && (cp_shift < CP_MIN4)) ||
                    (cp_shift > CP_MAX) ||
                    ((cp_shift >= CP_SURR_LO) && (cp_shift <= CP_SURR_HI));

    // next state for one byte
    always_comb
    begin
        upd = state_reg;
        if (item.has_byte && !state_reg.failed)
        begin
            // utf-8 decode
            if (state_reg.bytes_pending == 2'd0)
            begin
                if (b[7])
                begin
                    priority if (b[7:5] == 3'b110)
                    begin
                        upd.sequence_length   = SEQ_LEN2;
                        upd.partial_codepoint = {16'd0, b[4:0]};
                        upd.bytes_pending     = 2'd1;
                    end
                    else if (b[7:4] == 4'b1110)
                    begin
                        upd.sequence_length   = SEQ_LEN3;
                        upd.partial_codepoint = {17'd0, b[3:0]};
                        upd.bytes_pending     = 2'd2;
                    end
                    else if (b[7:3] == 5'b11110)
                    begin
                        upd.sequence_length   = SEQ_LEN4;
                        upd.partial_codepoint = {18'd0, b[2:0]};
                        upd.bytes_pending     = 2'd3;
                    end
                    else
                    begin
                        upd.failed = 1'b1;
                    end
                end
            end
            else if (b[7:6] != 2'b10)
            begin
                upd.failed = 1'b1;
            end
            else if (state_reg.bytes_pending == 2'd1)
            begin
                upd.failed            = cp_bad;
                upd.bytes_pending     = 2'd0;
                upd.sequence_length   = SEQ_NONE;
                upd.partial_codepoint = 21'd0;
            end
            else
            begin
                upd.partial_codepoint = cp_shift;
                upd.bytes_pending     = state_reg.bytes_pending - 2'd1;
            end

            // path rules
            priority if ((b == BYTE_BACKSLASH) || (b == BYTE_COLON))
            begin
                upd.failed = 1'b1;
            end
            else if (b == BYTE_SLASH)
            begin
                if (bad_component(state_reg))
                begin
                    upd.failed = 1'b1;
                end
                else
                begin
                    upd.component_length    = 2'd0;
                    upd.component_only_dots = 1'b1;
                end
            end
            else
            begin
                if (b != BYTE_DOT)
                begin
                    upd.component_only_dots = 1'b0;
                end
                if (state_reg.component_length != COMP_LEN_MAX)
                begin
                    upd.component_length = state_reg.component_length + 2'd1;
                end
            end
        end

        // verdict and clear at the end of a path
        res.load   = step && item.is_last;
        res.ok     = !upd.failed && (upd.bytes_pending == 2'd0) && !bad_component(upd);
        state_next = item.is_last ? STATE_CLEAR : upd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_CLEAR;
        end
        else if (step)
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    // no sequence open exactly when nothing is pending
    a_pend_seq: assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.failed |-> ((state_reg.bytes_pending == 2'd0) ==
                               (state_reg.sequence_length == SEQ_NONE)))
        else $error("pending count and sequence length disagree");

    // an open sequence is longer than its remaining bytes
    a_seq_len: assert property (@(posedge clk) disable iff (!rst_n)
        (!state_reg.failed && (state_reg.bytes_pending != 2'd0)) |->
        (state_reg.sequence_length > {1'b0, state_reg.bytes_pending}))
        else $error("sequence length too short for pending bytes");

    // an empty component counts as dots only
    a_empty_comp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.component_length == 2'd0) |-> state_reg.component_only_dots)
        else $error("empty component marked as not dots only");

    // state is clear after the last beat of a path
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (step && item.is_last) |=> (state_reg == STATE_CLEAR))
        else $error("state not cleared after verdict");
`endif

endmodule

// ===== sv/spuv_out_stage.sv =====
// result register for the verdict
module spuv_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  spuv_pkg::result_t   res,
    input  logic                out_ready,
    output logic                out_valid,
    output logic                path_ok,
    output logic                free
);
    import spuv_pkg::*;

    logic valid_reg;
    logic valid_next;
    logic ok_reg;

    // slot frees when the held beat is taken
    assign free       = !valid_reg || out_ready;
    assign valid_next = res.load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // verdict capture
    always_ff @(posedge clk)
    begin
        if (res.load)
        begin
            ok_reg <= res.ok;
        end
    end

    assign out_valid = valid_reg;
    assign path_ok   = ok_reg;

endmodule

// ===== sv/safe_path_utf8_validator.sv =====
// Safe relative path checker for byte streams. Takes one path byte per clock
// cycle on the input channel, back to back, with no gap between paths, save
// where a last beat waits for room on the output, and returns one verdict beat
// for the beat that carries is_last: path_ok is 1 only when the path is strict
// UTF-8 (no overlong form, surrogate or code point above U+10FFFF, no
// truncated sequence), holds no backslash or colon, and splits on '/' into
// components that are non-empty and neither "." nor "..". A beat with has_byte
// low and is_last low is ignored; one with is_last high alone ends the path,
// and an empty path is rejected. Path length is unlimited. The verdict passes
// the input register, where the last beat is held, and the result register,
// into which the checker writes it as the beat leaves. The rate of one beat
// per cycle is set by the state update in the checker.
// A beat without is_last proceeds even while a verdict waits on the output;
// a beat with is_last waits in the input register until that verdict is taken.
module safe_path_utf8_validator (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       has_byte,
    input  logic [7:0] path_byte,
    input  logic       is_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       path_ok
);
    import spuv_pkg::*;

    item_t   item;
    logic    item_valid;
    logic    take;
    logic    free;
    result_t res;

    // a held beat advances unless its verdict has no room
    assign take = item_valid && (!item.is_last || free);

    spuv_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .has_byte   (has_byte),
        .path_byte  (path_byte),
        .is_last    (is_last),
        .take       (take),
        .item       (item),
        .item_valid (item_valid)
    );

    spuv_checker u_chk (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (take),
        .item  (item),
        .res   (res)
    );

    spuv_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .path_ok   (path_ok),
        .free      (free)
    );

`ifndef SYNTHESIS
    // a verdict is never written over one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res.load |-> (!out_valid || out_ready))
        else $error("verdict overwrites a pending result");

    // a last beat always leaves a verdict behind
    a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
        (take && item.is_last) |=> out_valid)
        else $error("last beat produced no verdict");

    // only a last beat creates a result
    a_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid || out_ready) && !(take && item.is_last) |=> !out_valid)
        else $error("verdict without a last beat");
`endif

endmodule

// ===== tb/sv/tb.sv =====
// self-checking testbench for the safe path utf-8 validator
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // run length and timeout
    localparam int RANDOM_BEATS = 1900;
    localparam int CALM_BEATS   = 1650;
    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 10;
    localparam int N_DIR        = 27;

    // path bytes with a meaning of their own
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_COLON  = 8'h3a;

    // where the expected verdict of a beat comes from
    typedef enum logic [1:0] {
        V_REJECT,
        V_ACCEPT,
        V_MODEL
    } verdict_t;

    typedef struct packed {
        logic       hb;
        logic [7:0] b;
        logic       last;
        verdict_t   tag;
    } stim_row_t;

    // running state of the path being scored
    typedef struct {
        bit        failed;
        bit [1:0]  pending;
        bit [2:0]  seq_len;
        bit [20:0] code;
        bit [1:0]  comp_len;
        bit        only_dots;
    } path_track_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic       has_byte;
    logic [7:0] path_byte;
    logic       is_last;
    logic       out_valid;
    logic       out_ready;
    logic       path_ok;

    verdict_t    cur_tag;
    path_track_t trk;
    logic        verdict_q[$];
    logic [7:0]  path_q[$];
    stim_row_t   dir_rows[N_DIR];
    logic        want;
    bit          calm;
    int          fail_cnt;
    int          beats_sent;
    int          paths_sent;
    int          n_accepted;
    int          n_rejected;
    int          cycle_cnt;

    safe_path_utf8_validator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .has_byte  (has_byte),
        .path_byte (path_byte),
        .is_last   (is_last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .path_ok   (path_ok)
    );

    // clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // ---------------------------------------------------------------- predictor

    function void clear_track();
        trk.failed    = 1'b0;
        trk.pending   = 2'd0;
        trk.seq_len   = 3'd0;
        trk.code      = 21'd0;
        trk.comp_len  = 2'd0;
        trk.only_dots = 1'b1;
    endfunction

    function bit comp_is_bad();
        return trk.comp_len == 2'd0 || (trk.only_dots && trk.comp_len <= 2'd2);
    endfunction

    // append one expected verdict
    function void add_verdict(input logic v);
        verdict_q = {verdict_q, v};
    endfunction

    // utf-8 decoding of one byte
    function void decode_utf8(input logic [7:0] b);
        bit [20:0] cp;
        if (trk.pending == 2'd0) begin
            if (b[7] == 1'b0)
                return;
            if (b[7:5] == 3'b110) begin
                trk.seq_len = 3'd2;
                trk.code    = 21'(b[4:0]);
            end
            else if (b[7:4] == 4'b1110) begin
                trk.seq_len = 3'd3;
                trk.code    = 21'(b[3:0]);
            end
            else if (b[7:3] == 5'b11110) begin
                trk.seq_len = 3'd4;
                trk.code    = 21'(b[2:0]);
            end
            else begin
                trk.failed = 1'b1;
                return;
            end
            trk.pending = 2'(trk.seq_len - 3'd1);
            return;
        end
        if (b[7:6] != 2'b10) begin
            trk.failed = 1'b1;
            return;
        end
        trk.code    = {trk.code[14:0], b[5:0]};
        trk.pending = trk.pending - 2'd1;
        if (trk.pending == 2'd0) begin
            cp = trk.code;
            if ((trk.seq_len == 3'd2 && cp < 21'h80) ||
                (trk.seq_len == 3'd3 && cp < 21'h800) ||
                (trk.seq_len == 3'd4 && cp < 21'h10000) ||
                cp > 21'h10ffff ||
                (cp >= 21'hd800 && cp <= 21'hdfff))
                trk.failed = 1'b1;
            trk.seq_len = 3'd0;
            trk.code    = 21'd0;
        end
    endfunction

    // utf-8 decode and path rules on one byte, sticky once failed
    function void score_byte(input logic [7:0] b);
        if (trk.failed)
            return;
        decode_utf8(b);
        if (b == CH_BSLASH || b == CH_COLON) begin
            trk.failed = 1'b1;
            return;
        end
        if (b == CH_SLASH) begin
            if (comp_is_bad()) begin
                trk.failed = 1'b1;
                return;
            end
            trk.comp_len  = 2'd0;
            trk.only_dots = 1'b1;
            return;
        end
        if (b != CH_DOT)
            trk.only_dots = 1'b0;
        if (trk.comp_len < 2'd3)
            trk.comp_len = trk.comp_len + 2'd1;
    endfunction

    // every accepted beat with a byte or with is_last updates the path state
    always @(posedge clk) begin
        if (rst_n && in_valid && in_ready) begin
            if (has_byte)
                score_byte(path_byte);
            if (is_last) begin
                if (cur_tag == V_MODEL)
                    add_verdict(!trk.failed && trk.pending == 2'd0 && !comp_is_bad());
                else
                    add_verdict(cur_tag == V_ACCEPT);
                clear_track();
            end
        end
    end

    // ---------------------------------------------------------------- verdict check

    always @(posedge clk) begin
        if (rst_n && out_valid === 1'b1 && out_ready) begin
            if (verdict_q.size() == 0) begin
                $display("%0t: verdict %0b with none expected", $time, path_ok);
                fail_cnt++;
            end
            else begin
                want = verdict_q.pop_front();
                if (path_ok !== want) begin
                    $display("%0t: path_ok expected %0b, got %0b", $time, want, path_ok);
                    fail_cnt++;
                end
                if (path_ok === 1'b1)
                    n_accepted++;
                else
                    n_rejected++;
            end
        end
    end

    // timeout
    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt == LIMIT_CYCLES) begin
            $display("%0t: timeout, %0d verdicts outstanding", $time, verdict_q.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // verdict side back-pressure in random bursts
    initial begin : sink_ready
        int n;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 15) == 0) begin
                n = $urandom_range(1, 15);
                out_ready = 1'b0;
                repeat (n) @(negedge clk);
            end
            out_ready = 1'b1;
        end
    end

    // ---------------------------------------------------------------- stimulus

    // one input beat, called and returning at a falling edge
    task automatic send_beat(input logic hb, input logic [7:0] b, input logic last,
                             input verdict_t tag);
        if (!calm && $urandom_range(0, 9) == 0) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        in_valid  = 1'b1;
        has_byte  = hb;
        path_byte = b;
        is_last   = last;
        cur_tag   = tag;
        do @(posedge clk); while (!in_ready);
        if (hb || last)
            beats_sent++;
        @(negedge clk);
    endtask

    // hold the sender until every verdict is back
    task automatic drain_verdicts();
        in_valid = 1'b0;
        while (verdict_q.size() != 0) @(negedge clk);
    endtask

    // append one byte to the path being built
    function void add_byte(input logic [7:0] b);
        path_q = {path_q, b};
    endfunction

    function void push_utf8(input logic [20:0] code, input int n);
        case (n)
            1: add_byte({1'b0, code[6:0]});
            2: begin
                add_byte({3'b110, code[10:6]});
                add_byte({2'b10, code[5:0]});
            end
            3: begin
                add_byte({4'b1110, code[15:12]});
                add_byte({2'b10, code[11:6]});
                add_byte({2'b10, code[5:0]});
            end
            default: begin
                add_byte({5'b11110, code[20:18]});
                add_byte({2'b10, code[17:12]});
                add_byte({2'b10, code[11:6]});
                add_byte({2'b10, code[5:0]});
            end
        endcase
    endfunction

    // one component, well formed but for the dot-only names
    function void push_component();
        logic [7:0] b;
        logic [20:0] code;
        int n;
        if ($urandom_range(0, 9) == 0) begin
            // dot-only names: one or two dots are refused, three or more pass
            n = $urandom_range(1, 4);
            repeat (n) add_byte(CH_DOT);
            return;
        end
        n = $urandom_range(1, 5);
        repeat (n) begin
            case ($urandom_range(0, 9))
                6: add_byte(CH_DOT);
                7: push_utf8(21'($urandom_range(21'h80, 21'h7ff)), 2);
                8: begin
                    code = 21'($urandom_range(21'h800, 21'hffff));
                    if (code >= 21'hd800 && code <= 21'hdfff)
                        code = code + 21'h800;
                    push_utf8(code, 3);
                end
                9: push_utf8(21'($urandom_range(21'h10000, 21'h10ffff)), 4);
                default: begin
                    do b = 8'($urandom_range(0, 127));
                    while (b == CH_SLASH || b == CH_BSLASH || b == CH_COLON);
                    add_byte(b);
                end
            endcase
        end
    endfunction

    // one broken spot at a random place of the path
    function void add_fault();
        logic [7:0] tail[$];
        logic [20:0] code;
        int idx;
        int n;
        idx = $urandom_range(0, path_q.size());
        while (path_q.size() > idx) tail.push_front(path_q.pop_back());
        case ($urandom_range(0, 9))
            0: add_byte(CH_BSLASH);
            1: add_byte(CH_COLON);
            // stray continuation
            2: add_byte(8'($urandom_range(8'h80, 8'hbf)));
            // lead byte that no form allows
            3: add_byte(8'($urandom_range(8'hf8, 8'hff)));
            // lead byte left without its continuation
            4: add_byte(8'($urandom_range(8'hc0, 8'hf7)));
            // overlong form
            5: begin
                n = $urandom_range(2, 4);
                if (n == 2)
                    code = 21'($urandom_range(0, 21'h7f));
                else if (n == 3)
                    code = 21'($urandom_range(0, 21'h7ff));
                else
                    code = 21'($urandom_range(0, 21'hffff));
                push_utf8(code, n);
            end
            // surrogate
            6: push_utf8(21'($urandom_range(21'hd800, 21'hdfff)), 3);
            // beyond the last code point
            7: push_utf8(21'($urandom_range(21'h110000, 21'h1fffff)), 4);
            // empty component
            8: begin
                add_byte(CH_SLASH);
                add_byte(CH_SLASH);
            end
            // dot or dot-dot component
            default: begin
                add_byte(CH_SLASH);
                add_byte(CH_DOT);
                if ($urandom_range(0, 1))
                    add_byte(CH_DOT);
                add_byte(CH_SLASH);
            end
        endcase
        while (tail.size() != 0) add_byte(tail.pop_front());
    endfunction

    function void build_path();
        int r;
        int ncomp;
        path_q.delete();
        r = $urandom_range(0, 99);
        if (r < 3)
            return;
        if (r < 8) begin
            repeat ($urandom_range(1, 8)) add_byte(8'($urandom));
            return;
        end
        ncomp = (r < 11) ? $urandom_range(6, 12) : $urandom_range(1, 4);
        for (int i = 0; i < ncomp; i++) begin
            if (i > 0)
                add_byte(CH_SLASH);
            push_component();
        end
        if ($urandom_range(0, 99) < 30)
            add_fault();
    endfunction

    // path bytes, with idle beats mixed in, closed by is_last or an end marker
    task automatic send_path();
        bit marker_end;
        marker_end = (path_q.size() == 0) || ($urandom_range(0, 3) == 0);
        for (int i = 0; i < path_q.size(); i++) begin
            if ($urandom_range(0, 19) == 0)
                send_beat(1'b0, 8'($urandom), 1'b0, V_MODEL);
            send_beat(1'b1, path_q[i], !marker_end && i == path_q.size() - 1, V_MODEL);
        end
        if (marker_end)
            send_beat(1'b0, 8'($urandom), 1'b1, V_MODEL);
    endtask

    // ---------------------------------------------------------------- main sequence

    initial begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        has_byte  = 1'b0;
        path_byte = 8'h00;
        is_last   = 1'b0;
        cur_tag   = V_MODEL;
        calm      = 1'b0;
        clear_track();

        dir_rows = '{
            // empty path: end marker alone
            '{1'b0, 8'h00, 1'b1, V_REJECT},
            // idle beat is ignored, then a one-byte path
            '{1'b0, 8'hff, 1'b0, V_MODEL},
            '{1'b1, 8'h61, 1'b1, V_ACCEPT},
            // "." and ".."
            '{1'b1, CH_DOT, 1'b1, V_REJECT},
            '{1'b1, CH_DOT, 1'b0, V_MODEL},
            '{1'b1, CH_DOT, 1'b1, V_REJECT},
            // three dots make an ordinary name
            '{1'b1, CH_DOT, 1'b0, V_MODEL},
            '{1'b1, CH_DOT, 1'b0, V_MODEL},
            '{1'b1, CH_DOT, 1'b1, V_MODEL},
            // trailing slash
            '{1'b1, 8'h61, 1'b0, V_MODEL},
            '{1'b1, CH_SLASH, 1'b1, V_REJECT},
            // backslash and colon
            '{1'b1, CH_BSLASH, 1'b1, V_REJECT},
            '{1'b1, CH_COLON, 1'b1, V_REJECT},
            // lowest byte value is a plain character
            '{1'b1, 8'h00, 1'b1, V_ACCEPT},
            // bad lead byte, the rest of the path is ignored
            '{1'b1, 8'hff, 1'b0, V_MODEL},
            '{1'b1, 8'h61, 1'b1, V_REJECT},
            // overlong two-byte form
            '{1'b1, 8'hc0, 1'b0, V_MODEL},
            '{1'b1, 8'h80, 1'b1, V_REJECT},
            // above the last code point
            '{1'b1, 8'hf4, 1'b0, V_MODEL},
            '{1'b1, 8'h90, 1'b0, V_MODEL},
            '{1'b1, 8'h80, 1'b0, V_MODEL},
            '{1'b1, 8'h80, 1'b1, V_REJECT},
            // sequence cut off by the end marker
            '{1'b1, 8'he2, 1'b0, V_MODEL},
            '{1'b0, 8'h00, 1'b1, V_REJECT},
            // surrogate
            '{1'b1, 8'hed, 1'b0, V_MODEL},
            '{1'b1, 8'ha0, 1'b0, V_MODEL},
            '{1'b1, 8'h80, 1'b1, V_REJECT}
        };

        // reset
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed rows
        for (int k = 0; k < N_DIR; k++)
            send_beat(dir_rows[k].hb, dir_rows[k].b, dir_rows[k].last, dir_rows[k].tag);
        drain_verdicts();

        // random paths, mostly well formed
        while (beats_sent < RANDOM_BEATS) begin
            if (beats_sent >= CALM_BEATS)
                calm = 1'b1;
            build_path();
            send_path();
            paths_sent++;
            if (paths_sent == 80)
                drain_verdicts();
        end

        // wind down
        drain_verdicts();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("%0d byte and end beats sent: %0d directed rows, then %0d random paths",
                 beats_sent, N_DIR, paths_sent);
        $display("verdicts seen: %0d accepted, %0d rejected, %0d mismatches", n_accepted,
                 n_rejected, fail_cnt);
        if (fail_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
sv/spuv_pkg.sv
sv/spuv_in_stage.sv
sv/spuv_checker.sv
sv/spuv_out_stage.sv
sv/safe_path_utf8_validator.sv
tb/sv/tb.sv
